// ===== hdl/base32_group_encoder_assert.svh =====
// assertion macros used by the encoder back stage
`ifndef BASE32_GROUP_ENCODER_ASSERT_SVH
`define BASE32_GROUP_ENCODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define B32GE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define B32GE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/b32ge_pkg.sv =====
package b32ge_pkg;

    // one decoded input byte: up to three 5-bit character codes
    typedef struct packed {
        logic [2:0][4:0] code;
        logic [1:0]      nchar;
        logic            last;
    } t_grp_entry;

    localparam logic [6:0] SYM_DASH           = 7'd45;
    localparam logic [3:0] GROUP_LENGTH_RESET = 4'd4;
    localparam logic       REG_GROUP_LENGTH   = 1'b0;

    // rfc 4648 base32 alphabet
    function automatic logic [6:0] b32_char(input logic [4:0] code);
        logic [6:0] ch;
        if (code < 5'd26) begin
            ch = 7'd65 + 7'(code);
        end else begin
            ch = 7'd50 + 7'(code - 5'd26);
        end
        return ch;
    endfunction

endpackage

// ===== hdl/b32ge_front.sv =====
module b32ge_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_final_byte,
    output b32ge_pkg::t_grp_entry o_entry
);

    logic [3:0]  r_left_bits, n_left_bits;
    logic [2:0]  r_left_cnt, n_left_cnt;
    logic [11:0] acc;
    logic [3:0]  cnt;
    logic        two;
    logic [4:0]  c0, c1, flush_code;
    logic [2:0]  rem;
    logic [3:0]  rbits;

    assign acc = {r_left_bits, i_data_byte};
    assign cnt = {1'b0, r_left_cnt} + 4'd8;
    assign two = (cnt >= 4'd10);
    assign c0  = 5'(acc >> (cnt - 4'd5));
    assign c1  = 5'(acc >> (cnt - 4'd10));
    assign rem = two ? 3'(cnt - 4'd10) : 3'(cnt - 4'd5);
    assign rbits = 4'(acc & ((12'd1 << rem) - 12'd1));
    // leftover bits left-aligned and zero-filled to five bits
    assign flush_code = 5'(9'(rbits) << (3'd5 - rem));

    always_comb begin
        o_entry.code[0] = c0;
        o_entry.code[1] = two ? c1 : flush_code;
        o_entry.code[2] = flush_code;
        o_entry.nchar   = two ? 2'd2 : 2'd1;
        o_entry.last    = i_final_byte;
        if (i_final_byte && (rem != 3'd0)) begin
            o_entry.nchar = o_entry.nchar + 2'd1;
        end
    end

    always_comb begin
        n_left_bits = r_left_bits;
        n_left_cnt  = r_left_cnt;
        if (i_accept) begin
            n_left_bits = i_final_byte ? 4'd0 : rbits;
            n_left_cnt  = i_final_byte ? 3'd0 : rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_bits <= 4'd0;
            r_left_cnt  <= 3'd0;
        end else begin
            r_left_bits <= n_left_bits;
            r_left_cnt  <= n_left_cnt;
        end
    end

endmodule

// ===== hdl/b32ge_fifo.sv =====
module b32ge_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  b32ge_pkg::t_grp_entry i_entry,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output b32ge_pkg::t_grp_entry o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b32ge_pkg::t_grp_entry r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == CW'(0));
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? AW'(0) : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? AW'(0) : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hdl/b32ge_back.sv =====
`include "base32_group_encoder_assert.svh"

module b32ge_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [3:0]            i_group_length,
    input  logic                  i_q_empty,
    input  b32ge_pkg::t_grp_entry i_q_head,
    output logic                  o_q_pop,
    input  logic                  i_pop,
    output logic                  o_valid,
    output logic [6:0]            o_symbol,
    output logic                  o_end_of_run,
    output logic                  o_end_of_message
);

    logic       r_out_valid, n_out_valid;
    logic [6:0] r_symbol, n_symbol;
    logic       r_eor, n_eor;
    logic       r_eom, n_eom;
    logic [1:0] r_idx, n_idx;
    logic [3:0] r_gpos, n_gpos;
    logic       r_any, n_any;
    logic       load;
    logic       dash;
    logic       last_char;
    logic       msg_done;

    assign load      = !i_q_empty && (!r_out_valid || i_pop);
    assign dash      = (i_group_length != 4'd0) && r_any && (r_gpos >= i_group_length);
    assign last_char = (r_idx == (i_q_head.nchar - 2'd1));
    assign o_q_pop   = load && !dash && last_char;
    assign msg_done  = o_q_pop && i_q_head.last;

    always_comb begin
        n_out_valid = r_out_valid;
        n_symbol    = r_symbol;
        n_eor       = r_eor;
        n_eom       = r_eom;
        n_idx       = r_idx;
        n_gpos      = r_gpos;
        n_any       = r_any;
        if (i_pop) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_out_valid = 1'b1;
            if (dash) begin
                // separator first, the character follows once the dash is popped
                n_symbol = b32ge_pkg::SYM_DASH;
                n_eor    = 1'b0;
                n_eom    = 1'b0;
                n_gpos   = 4'd0;
            end else begin
                n_symbol = b32ge_pkg::b32_char(i_q_head.code[r_idx]);
                n_eor    = last_char;
                n_eom    = last_char && i_q_head.last;
                n_gpos   = (r_gpos == 4'd15) ? r_gpos : r_gpos + 4'd1;
                n_any    = 1'b1;
                n_idx    = r_idx + 2'd1;
                if (last_char) begin
                    n_idx = 2'd0;
                    if (i_q_head.last) begin
                        n_gpos = 4'd0;
                        n_any  = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_symbol <= n_symbol;
        r_eor    <= n_eor;
        r_eom    <= n_eom;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
            r_gpos      <= 4'd0;
            r_any       <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_gpos      <= n_gpos;
            r_any       <= n_any;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_symbol         = r_symbol;
    assign o_end_of_run     = r_eor;
    assign o_end_of_message = r_eom;

    `B32GE_ASSERT_NOW(a_pop_needs_entry, o_q_pop, !i_q_empty, "queue popped while empty")
    `B32GE_ASSERT_NOW(a_idx_in_range, !i_q_empty, r_idx < i_q_head.nchar, "char index past entry")
    `B32GE_ASSERT_NOW(a_idle_group, !r_any, r_gpos == 4'd0, "group position set with no output")
    `B32GE_ASSERT_NEXT(a_eom_clears, msg_done, !r_any && (r_idx == 2'd0), "message end left state")

endmodule

// ===== hdl/base32_group_encoder.sv =====
// Unpadded base32 encoder (rfc 4648 alphabet) with optional dash grouping.
// Bytes go in through a queue-style push/full port, with i_final_byte set on
// the last byte of a message; ascii characters come out through a
// queue-style empty/pop port, one character per transfer, with end_of_run
// on the last character a byte produced and end_of_message on the last
// character of the message. The front stage takes a byte every cycle while
// the decode queue has room and splits it into one to three 5-bit codes;
// the back stage drains them through a single output register at one
// character per cycle while the output is popped, inserting a dash between
// groups of group_length characters of a message (register 0 at byte
// address 0, reset value 4, 0 turns dashes off). A message of zero bytes
// cannot be sent.
module base32_group_encoder #(
    parameter int QUEUE_DEPTH = 4  // decode queue entries, 2 or more
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    // character output
    output logic        empty,
    input  logic        pop,
    output logic [6:0]  o_symbol,
    output logic        o_end_of_run,
    output logic        o_end_of_message,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0]            r_group_length;
    logic                  cfg_wr;
    logic                  in_xfer;
    logic                  out_xfer;
    logic                  q_pop;
    logic                  q_empty;
    logic                  out_valid;
    b32ge_pkg::t_grp_entry front_entry;
    b32ge_pkg::t_grp_entry q_head;

    // register file: one 4-bit register, decoded on the word index
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == b32ge_pkg::REG_GROUP_LENGTH);
    assign prdata = (paddr[2] == b32ge_pkg::REG_GROUP_LENGTH) ? 32'(r_group_length) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_length <= b32ge_pkg::GROUP_LENGTH_RESET;
        end else if (cfg_wr) begin
            r_group_length <= pwdata[3:0];
        end
    end

    // handshakes
    assign in_xfer  = push && !full;
    assign out_xfer = pop && !empty;
    assign empty    = !out_valid;

    // front: leftover bits and code split
    b32ge_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_xfer),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_entry      (front_entry)
    );

    // decode queue between front and back
    b32ge_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_entry (front_entry),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // back: grouping, alphabet lookup, output register
    b32ge_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_group_length   (r_group_length),
        .i_q_empty        (q_empty),
        .i_q_head         (q_head),
        .o_q_pop          (q_pop),
        .i_pop            (out_xfer),
        .o_valid          (out_valid),
        .o_symbol         (o_symbol),
        .o_end_of_run     (o_end_of_run),
        .o_end_of_message (o_end_of_message)
    );

endmodule
